@@ hdl/krt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and codes for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam logic [2:0] OP_SEARCH   = 3'd0;
  localparam logic [2:0] OP_INSERT   = 3'd1;
  localparam logic [2:0] OP_DELETE   = 3'd2;
  localparam logic [2:0] OP_DEL_ROLE = 3'd3;
  localparam logic [2:0] OP_MAX_HP   = 3'd4;
  localparam logic [2:0] OP_DUMP     = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_mid;
    logic [31:0] key_low;
    logic [15:0] hit_points;
    logic [15:0] mana_points;
    logic [15:0] move_speed;
    logic [15:0] reach;
    logic [63:0] role_high;
    logic [15:0] role_low;
  } record_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request
    logic scan;    // read the slot at the scan address
    logic finish;  // commit table updates, fetch the reported slot
    logic report;  // present the final result
  } ctrl_cmd_t;

endpackage

@@ hdl/krt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_ctrl
// Sequencer: walks the scan address over every slot, then finishes and reports.
// ----------------------------------------------------------------------------
module krt_ctrl #(
  parameter int ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  output krt_pkg::ctrl_cmd_t         cmd,
  output logic [$clog2(ENTRIES)-1:0] scan_addr
);
  import krt_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH, S_REPORT} state_t;

  state_t           state;
  logic [IDX_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (start) state <= S_SCAN;
        end
        S_SCAN: begin
          // advance one slot a cycle
          if (cnt == LAST_SLOT) state <= S_DRAIN;
          else cnt <= cnt + 1'b1;
        end
        S_DRAIN:  state <= S_FINISH;
        S_FINISH: state <= S_REPORT;
        S_REPORT: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state != S_IDLE);
  assign scan_addr  = cnt;
  assign cmd.load   = (state == S_IDLE) && start;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.finish = (state == S_FINISH);
  assign cmd.report = (state == S_REPORT);

endmodule

@@ hdl/krt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_datapath
// Record memory, occupancy flags, match logic and result formatting.
// ----------------------------------------------------------------------------
module krt_datapath #(
  parameter int ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  krt_pkg::ctrl_cmd_t         cmd,
  input  logic [$clog2(ENTRIES)-1:0] scan_addr,
  input  logic [2:0]                 operation,
  input  krt_pkg::record_t           req_in,
  output logic                       result_valid,
  output logic [2:0]                 status,
  output logic [5:0]                 slot_index,
  output krt_pkg::record_t           rec_out,
  output logic                       last_item
);
  import krt_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  record_t          mem [ENTRIES];
  logic [ENTRIES-1:0] occ;

  logic [2:0]       op;
  record_t          req;
  record_t          rd_data;
  logic [IDX_W-1:0] rd_slot;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_addr;

  logic             key_found, free_found, role_found, best_found, dump_found;
  logic [IDX_W-1:0] key_slot, free_slot, role_slot, best_slot;
  logic [15:0]      best_hp;

  logic             occ_hit, key_eq, role_eq, nothing_above;
  logic             do_insert, do_delete;

  assign occ_hit = rd_valid && occ[rd_slot];
  assign key_eq  = (rd_data.key_high == req.key_high) && (rd_data.key_mid == req.key_mid)
                   && (rd_data.key_low == req.key_low);
  assign role_eq = (rd_data.role_high == req.role_high) && (rd_data.role_low == req.role_low);

  always_comb begin
    nothing_above = 1'b1;
    for (int j = 0; j < ENTRIES; j++) begin
      if ((IDX_W'(j) > rd_slot) && occ[j]) nothing_above = 1'b0;
    end
  end

  assign do_insert = cmd.finish && (op == OP_INSERT) && !key_found && free_found;
  assign do_delete = cmd.finish && (op == OP_DELETE) && key_found;
  assign rd_addr   = cmd.scan ? scan_addr : ((op == OP_MAX_HP) ? best_slot : key_slot);

  // Record memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_insert) mem[free_slot] <= req;
    rd_data <= mem[rd_addr];
    rd_slot <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= operation;
      req <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ        <= '0;
      rd_valid   <= 1'b0;
      key_found  <= 1'b0;
      free_found <= 1'b0;
      role_found <= 1'b0;
      best_found <= 1'b0;
      dump_found <= 1'b0;
      key_slot   <= '0;
      free_slot  <= '0;
      role_slot  <= '0;
      best_slot  <= '0;
      best_hp    <= '0;
    end else begin
      rd_valid <= cmd.scan;
      if (cmd.load) begin
        key_found  <= 1'b0;
        free_found <= 1'b0;
        role_found <= 1'b0;
        best_found <= 1'b0;
        dump_found <= 1'b0;
        key_slot   <= '0;
        best_slot  <= '0;
      end else if (rd_valid) begin
        if (occ_hit && key_eq && !key_found) begin
          key_found <= 1'b1;
          key_slot  <= rd_slot;
        end
        if (!occ[rd_slot] && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= rd_slot;
        end
        if ((op == OP_DEL_ROLE) && occ_hit && role_eq) begin
          occ[rd_slot] <= 1'b0;
          if (!role_found) begin
            role_found <= 1'b1;
            role_slot  <= rd_slot;
          end
        end
        // ties go to the later slot
        if (occ_hit && (!best_found || rd_data.hit_points >= best_hp)) begin
          best_found <= 1'b1;
          best_slot  <= rd_slot;
          best_hp    <= rd_data.hit_points;
        end
        if ((op == OP_DUMP) && occ_hit) dump_found <= 1'b1;
      end
      if (do_insert) occ[free_slot] <= 1'b1;
      if (do_delete) occ[key_slot] <= 1'b0;
    end
  end

  // Result formatting.
  always_comb begin
    result_valid = 1'b0;
    status       = ST_OK;
    slot_index   = '0;
    rec_out      = '0;
    last_item    = 1'b1;
    if (rd_valid && (op == OP_DUMP) && occ_hit) begin
      result_valid = 1'b1;
      slot_index   = 6'(rd_slot);
      rec_out      = rd_data;
      last_item    = nothing_above;
    end else if (cmd.report) begin
      result_valid = 1'b1;
      case (op)
        OP_SEARCH, OP_DELETE: begin
          if (key_found) begin
            slot_index = 6'(rd_slot);
            rec_out    = rd_data;
          end else begin
            status = ST_NOT_FOUND;
          end
        end
        OP_INSERT: begin
          if (key_found) begin
            status     = ST_DUPLICATE;
            slot_index = 6'(rd_slot);
            rec_out    = rd_data;
          end else if (free_found) begin
            slot_index = 6'(free_slot);
            rec_out    = req;
          end else begin
            status = ST_FULL;
          end
        end
        OP_DEL_ROLE: begin
          if (role_found) slot_index = 6'(role_slot);
          else status = ST_NOT_FOUND;
        end
        OP_MAX_HP: begin
          if (best_found) begin
            slot_index = 6'(rd_slot);
            rec_out    = rd_data;
          end else begin
            status = ST_EMPTY;
          end
        end
        OP_DUMP: begin
          result_valid = !dump_found;
          status       = ST_EMPTY;
        end
        default: status = ST_NOT_FOUND;
      endcase
    end
  end

endmodule

@@ hdl/keyed_record_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table
// Linear-search table of name-keyed records with six operations.
// ----------------------------------------------------------------------------
// Usage: pulse start with an operation while busy is low. Every request scans
// every slot, one per cycle, as it walks the single read port of the record
// memory, then passes through drain, finish and report cycles. Results appear
// for exactly one cycle with result_valid high and cannot be held off, so the
// receiver must take them as they come. A dump streams its records during
// the scan; every other operation reports once at the end. last_item marks
// the final result of each request.
module keyed_record_table #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [63:0] key_high,
  input  logic [63:0] key_mid,
  input  logic [31:0] key_low,
  input  logic [15:0] hit_points,
  input  logic [15:0] mana_points,
  input  logic [15:0] move_speed,
  input  logic [15:0] reach,
  input  logic [63:0] role_high,
  input  logic [15:0] role_low,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [5:0]  slot_index,
  output logic [63:0] out_key_high,
  output logic [63:0] out_key_mid,
  output logic [31:0] out_key_low,
  output logic [15:0] out_hit_points,
  output logic [15:0] out_mana_points,
  output logic [15:0] out_move_speed,
  output logic [15:0] out_reach,
  output logic [63:0] out_role_high,
  output logic [15:0] out_role_low,
  output logic        last_item
);
  import krt_pkg::*;

  ctrl_cmd_t                  cmd;
  logic [$clog2(ENTRIES)-1:0] scan_addr;
  record_t                    req_in;
  record_t                    rec_out;

  // Pack the request fields into one record.
  assign req_in = '{key_high: key_high, key_mid: key_mid, key_low: key_low,
                    hit_points: hit_points, mana_points: mana_points,
                    move_speed: move_speed, reach: reach,
                    role_high: role_high, role_low: role_low};

  krt_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .scan_addr (scan_addr)
  );

  krt_datapath #(.ENTRIES(ENTRIES)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .scan_addr    (scan_addr),
    .operation    (operation),
    .req_in       (req_in),
    .result_valid (result_valid),
    .status       (status),
    .slot_index   (slot_index),
    .rec_out      (rec_out),
    .last_item    (last_item)
  );

  assign out_key_high    = rec_out.key_high;
  assign out_key_mid     = rec_out.key_mid;
  assign out_key_low     = rec_out.key_low;
  assign out_hit_points  = rec_out.hit_points;
  assign out_mana_points = rec_out.mana_points;
  assign out_move_speed  = rec_out.move_speed;
  assign out_reach       = rec_out.reach;
  assign out_role_high   = rec_out.role_high;
  assign out_role_low    = rec_out.role_low;

endmodule
